### hdl/assert_macros.svh
// Assertion macros shared by the level bar animator RTL.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_CLK(label, !(cond), msg)

`endif

### hdl/lbaph_pkg.sv
// Shared types and constants of the level bar animator with peak hold.
// No dependencies; imported by the interfaces and every module.
`default_nettype none

package lbaph_pkg;

    localparam int COLUMNS = 21;
    localparam int LEVELS  = 4;
    localparam int NTHR    = 4;

    localparam int COL_W       = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int COL_FIELD_W = 5;
    localparam int LVL_W       = 3;
    localparam int BYTE_W      = 8;
    localparam int THR_W       = 9;
    localparam int PERIOD_W    = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 9;

    // Register reset values
    localparam logic [BYTE_W-1:0]   RSSI_FLOOR_RST = 8'd10;
    localparam logic [BYTE_W-1:0]   PAUSE_GATE_RST = 8'd18;
    localparam logic [PERIOD_W-1:0] FALL_PER_RST   = 3'd5;
    localparam logic [THR_W-1:0]    THR_RST [NTHR] = '{9'd20, 9'd40, 9'd70, 9'd110};

    // Hash and scaling constants
    localparam logic [15:0] HASH_PH_MUL  = 16'd37;
    localparam logic [15:0] HASH_COL_MUL = 16'd157;
    localparam logic [15:0] HASH_SUM_MUL = 16'd13;
    localparam logic [7:0]  SCALE_BASE   = 8'd40;
    localparam logic [7:0]  SCALE_MOD    = 8'd216;
    localparam logic [7:0]  ACT_MAX      = 8'd255;
    localparam int          TARGET_MAX   = 400;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RSSI_FLOOR = 3'd0,
        CFG_PAUSE_GATE = 3'd1,
        CFG_FALL_PER   = 3'd2,
        CFG_THR_ONE    = 3'd3,
        CFG_THR_TWO    = 3'd4,
        CFG_THR_THREE  = 3'd5,
        CFG_THR_FOUR   = 3'd6
    } lbaph_cfg_idx_t;

    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] col;
        logic             last;
    } lbaph_tag_t;

    typedef struct packed {
        logic [LVL_W-1:0] bar;
        logic [LVL_W-1:0] peak;
    } lbaph_entry_t;

endpackage

`default_nettype wire

### hdl/lbaph_if.sv
// Valid/ready channels of the level bar animator: sample words in, column words out.
// Depends on lbaph_pkg for the field widths.
`default_nettype none

interface lbaph_sample_if import lbaph_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              action;
    logic [BYTE_W-1:0] rssi;
    logic [BYTE_W-1:0] snr;
    logic              railed;

    modport source (output valid, action, rssi, snr, railed, input ready);
    modport sink (input valid, action, rssi, snr, railed, output ready);
endinterface

interface lbaph_bar_if import lbaph_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [COL_FIELD_W-1:0] column;
    logic [LVL_W-1:0]       bar_level;
    logic [LVL_W-1:0]       peak_level;
    logic                   last;

    modport source (output valid, column, bar_level, peak_level, last, input ready);
    modport sink (input valid, column, bar_level, peak_level, last, output ready);
endinterface

`default_nettype wire

### hdl/lbaph_target.sv
// Three-stage column target pipeline: hash, scale, then adjust, wobble and clamp.
// Depends on lbaph_pkg; the whole pipeline advances on en.
`default_nettype none

module lbaph_target import lbaph_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire lbaph_tag_t        issue,
    input  wire logic [BYTE_W-1:0] phase,
    input  wire logic [BYTE_W-1:0] act,
    output lbaph_tag_t             tag,
    output logic [THR_W-1:0]       target,
    output logic                   busy
);

    lbaph_tag_t        tag_a_reg, tag_b_reg, tag_c_reg;
    logic [7:0]        mix_a_reg, mix_b_reg;
    logic [15:0]       prod_b_reg;
    logic [THR_W-1:0]  target_c_reg;

    logic [15:0]       hash;
    logic [7:0]        mix_next;
    logic [7:0]        mix_mod;
    logic [7:0]        factor;
    logic [15:0]       prod_next;
    logic [16:0]       div_sum;
    logic [7:0]        quot;
    logic [THR_W-1:0]  adj;
    logic signed [4:0] wob;
    logic signed [2:0] act_hi;
    logic signed [5:0] wob_prod;
    logic signed [10:0] t_sum;
    logic [THR_W-1:0]  target_next;

    // stage A: hash of phase and column
    always_comb
    begin
        hash = (16'(phase) * HASH_PH_MUL) ^ (16'(issue.col) * HASH_COL_MUL)
             ^ ((16'(phase) + 16'(issue.col)) * HASH_SUM_MUL);
        mix_next = hash[7:0] ^ hash[15:8];
    end

    // stage B: scale activity by 40 + mix mod 216
    always_comb
    begin
        mix_mod   = (mix_a_reg >= SCALE_MOD) ? (mix_a_reg - SCALE_MOD) : mix_a_reg;
        factor    = SCALE_BASE + mix_mod;
        prod_next = 16'(act) * 16'(factor);
    end

    // stage C: divide by 255, shift or boost, wobble, clamp
    always_comb
    begin
        div_sum = 17'(prod_b_reg) + 17'(prod_b_reg[15:8]) + 17'd1;
        quot    = div_sum[15:8];
        priority if (mix_b_reg[2:0] == 3'd0)
        begin
            adj = THR_W'(quot) + THR_W'(act[7:1]);
        end
        else if (mix_b_reg[2:0] == 3'd1)
        begin
            adj = THR_W'(quot[7:2]);
        end
        else if (mix_b_reg[3:0] == 4'd2)
        begin
            adj = THR_W'(quot[7:1]);
        end
        else
        begin
            adj = THR_W'(quot);
        end
        wob      = $signed({2'b00, mix_b_reg[5:3]}) - 5'sd3;
        act_hi   = $signed({1'b0, act[7:6]});
        wob_prod = 6'(wob) * 6'(act_hi);
        t_sum    = $signed({2'b00, adj}) + 11'(wob_prod);
        priority if (t_sum < 11'sd0)
        begin
            target_next = '0;
        end
        else if (t_sum > 11'(TARGET_MAX))
        begin
            target_next = THR_W'(TARGET_MAX);
        end
        else
        begin
            target_next = THR_W'(t_sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            tag_c_reg <= '0;
        end
        else if (en)
        begin
            tag_a_reg <= issue;
            tag_b_reg <= tag_a_reg;
            tag_c_reg <= tag_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mix_a_reg    <= mix_next;
            mix_b_reg    <= mix_a_reg;
            prod_b_reg   <= prod_next;
            target_c_reg <= target_next;
        end
    end

    assign tag    = tag_c_reg;
    assign target = target_c_reg;
    assign busy   = tag_a_reg.valid || tag_b_reg.valid;

endmodule

`default_nettype wire

### hdl/level_bar_animator_peak_hold.sv
// Level bar animator with peak hold. A sample word (action 0) produces COLUMNS column
// words, column 0 first, last set on the final one; a clear word (action 1) zeroes
// bars, peaks, phase and fall counter, stays idle and produces nothing. A sample passes
// through the accept, the setup state for activity, fall tick and phase, the issue of one
// column per cycle while the output is not stalled, the drain of the last column
// through the four-stage hash/scale/update pipeline, and the return to idle. The
// bar/peak memory takes one read and one write per cycle. Output stalls hold the whole
// column pipeline. No new word is taken until the previous sample has drained. The
// user must write registers only while idle; the block itself does not enforce this.
`default_nettype none
`include "assert_macros.svh"

module level_bar_animator_peak_hold import lbaph_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    lbaph_sample_if.sink               sample,
    lbaph_bar_if.source                bars,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [1:0] {S_IDLE, S_SETUP, S_RUN, S_DRAIN} state_t;

    // configuration
    logic [BYTE_W-1:0]   rssi_floor_reg;
    logic [BYTE_W-1:0]   pause_gate_reg;
    logic [PERIOD_W-1:0] fall_per_reg;
    logic [THR_W-1:0]    thr_reg [NTHR];

    // control and state
    state_t              state_reg, state_next;
    logic [BYTE_W-1:0]   act_reg, act_next;
    logic                decay_reg, decay_next;
    logic                drop_reg, drop_next;
    logic [BYTE_W-1:0]   phase_reg, phase_next;
    logic [PERIOD_W-1:0] fall_cnt_reg, fall_cnt_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [COLUMNS-1:0]  valid_bits_reg, valid_bits_next;
    lbaph_tag_t          tag_d_reg, tag_d_next;
    logic [THR_W-1:0]    target_d_reg;

    // output word
    logic                   out_valid_reg, out_valid_next;
    logic [COL_FIELD_W-1:0] out_col_reg;
    logic [LVL_W-1:0]       out_bar_reg, out_peak_reg;
    logic                   out_last_reg;

    // memory
    lbaph_entry_t        bar_mem [COLUMNS];
    lbaph_entry_t        rd_entry_reg;

    logic                adv;
    logic                accept;
    logic                in_flight;
    lbaph_tag_t          issue;
    lbaph_tag_t          tgt_tag;
    logic [THR_W-1:0]    tgt_target;
    logic                tgt_busy;
    logic [11:0]         act_sum;
    logic [BYTE_W-1:0]   act_in;
    logic [PERIOD_W-1:0] cnt_inc;
    logic [LVL_W-1:0]    want;
    lbaph_entry_t        cur;
    lbaph_entry_t        upd;
    logic                wr_en;

    assign adv    = !out_valid_reg || bars.ready;
    assign accept = sample.valid && sample.ready;
    assign sample.ready = (state_reg == S_IDLE);
    assign in_flight    = tgt_busy || tgt_tag.valid || tag_d_reg.valid;

    assign issue.valid = (state_reg == S_RUN) && adv;
    assign issue.col   = col_reg;
    assign issue.last  = (col_reg == COL_W'(COLUMNS - 1));

    lbaph_target u_target (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (adv),
        .issue  (issue),
        .phase  (phase_reg),
        .act    (act_reg),
        .tag    (tgt_tag),
        .target (tgt_target),
        .busy   (tgt_busy)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rssi_floor_reg <= RSSI_FLOOR_RST;
            pause_gate_reg <= PAUSE_GATE_RST;
            fall_per_reg   <= FALL_PER_RST;
            thr_reg        <= THR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RSSI_FLOOR: rssi_floor_reg <= cfg_data[BYTE_W-1:0];
                CFG_PAUSE_GATE: pause_gate_reg <= cfg_data[BYTE_W-1:0];
                CFG_FALL_PER:   fall_per_reg   <= cfg_data[PERIOD_W-1:0];
                CFG_THR_ONE:    thr_reg[0]     <= cfg_data[THR_W-1:0];
                CFG_THR_TWO:    thr_reg[1]     <= cfg_data[THR_W-1:0];
                CFG_THR_THREE:  thr_reg[2]     <= cfg_data[THR_W-1:0];
                CFG_THR_FOUR:   thr_reg[3]     <= cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // activity of the incoming word, saturated
    always_comb
    begin
        act_sum = 12'(sample.rssi) + {1'b0, sample.snr, 3'b000};
        if (sample.railed || (sample.rssi < rssi_floor_reg))
        begin
            act_in = '0;
        end
        else if (act_sum > 12'(ACT_MAX))
        begin
            act_in = ACT_MAX;
        end
        else
        begin
            act_in = act_sum[BYTE_W-1:0];
        end
    end

    // quantise the target: last threshold reached wins
    always_comb
    begin
        want = '0;
        for (int i = 0; i < NTHR; i++)
        begin
            if ((i < LEVELS) && (target_d_reg >= thr_reg[i]))
            begin
                want = LVL_W'(i + 1);
            end
        end
        if (want > LVL_W'(LEVELS))
        begin
            want = LVL_W'(LEVELS);
        end
    end

    // bar and peak update of the column in stage D
    always_comb
    begin
        cur = valid_bits_reg[tag_d_reg.col] ? rd_entry_reg : '0;
        upd = cur;
        if (decay_reg)
        begin
            upd.bar  = '0;
            upd.peak = (cur.bar > cur.peak) ? cur.bar : cur.peak;
            if (drop_reg && (upd.peak != '0))
            begin
                upd.peak = upd.peak - LVL_W'(1);
            end
        end
        else
        begin
            if (want > cur.bar)
            begin
                upd.bar = cur.bar + LVL_W'(1);
            end
            else if (want < cur.bar)
            begin
                upd.bar = cur.bar - LVL_W'(1);
            end
            upd.peak = (upd.bar > cur.peak) ? upd.bar : cur.peak;
            if (drop_reg && (upd.peak > upd.bar))
            begin
                upd.peak = upd.peak - LVL_W'(1);
            end
        end
    end

    assign wr_en = adv && tag_d_reg.valid;

    // next-state logic
    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        decay_next      = decay_reg;
        drop_next       = drop_reg;
        phase_next      = phase_reg;
        fall_cnt_next   = fall_cnt_reg;
        col_next        = col_reg;
        valid_bits_next = valid_bits_reg;
        tag_d_next      = tag_d_reg;
        out_valid_next  = out_valid_reg;
        cnt_inc         = fall_cnt_reg + PERIOD_W'(1);

        if (adv)
        begin
            tag_d_next     = tgt_tag;
            out_valid_next = tag_d_reg.valid;
        end
        if (wr_en)
        begin
            valid_bits_next[tag_d_reg.col] = 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (sample.action)
                    begin
                        valid_bits_next = '0;
                        phase_next      = '0;
                        fall_cnt_next   = '0;
                    end
                    else
                    begin
                        act_next   = act_in;
                        state_next = S_SETUP;
                    end
                end
            end
            S_SETUP:
            begin
                decay_next = (act_reg < pause_gate_reg);
                if (cnt_inc >= fall_per_reg)
                begin
                    fall_cnt_next = '0;
                    drop_next     = 1'b1;
                end
                else
                begin
                    fall_cnt_next = cnt_inc;
                    drop_next     = 1'b0;
                end
                if (act_reg >= pause_gate_reg)
                begin
                    phase_next = phase_reg + BYTE_W'(1);
                end
                col_next   = '0;
                state_next = S_RUN;
            end
            S_RUN:
            begin
                if (adv)
                begin
                    if (issue.last)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        col_next = col_reg + COL_W'(1);
                    end
                end
            end
            S_DRAIN:
            begin
                if (!in_flight)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            act_reg        <= '0;
            decay_reg      <= 1'b0;
            drop_reg       <= 1'b0;
            phase_reg      <= '0;
            fall_cnt_reg   <= '0;
            col_reg        <= '0;
            valid_bits_reg <= '0;
            tag_d_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            act_reg        <= act_next;
            decay_reg      <= decay_next;
            drop_reg       <= drop_next;
            phase_reg      <= phase_next;
            fall_cnt_reg   <= fall_cnt_next;
            col_reg        <= col_next;
            valid_bits_reg <= valid_bits_next;
            tag_d_reg      <= tag_d_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload of stage D and of the output word
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            target_d_reg <= tgt_target;
            out_col_reg  <= COL_FIELD_W'(tag_d_reg.col);
            out_bar_reg  <= upd.bar;
            out_peak_reg <= upd.peak;
            out_last_reg <= tag_d_reg.last;
        end
    end

    // bar/peak memory: read as a column enters stage D, write back as it leaves.
    // Columns of one sample are distinct and samples do not overlap, so no forwarding.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bar_mem[tag_d_reg.col] <= upd;
        end
        if (adv && tgt_tag.valid)
        begin
            rd_entry_reg <= bar_mem[tgt_tag.col];
        end
    end

    assign bars.valid      = out_valid_reg;
    assign bars.column     = out_col_reg;
    assign bars.bar_level  = out_bar_reg;
    assign bars.peak_level = out_peak_reg;
    assign bars.last       = out_last_reg;

    `ASSERT_CLK(a_peak_not_below_bar, bars.valid |-> bars.peak_level >= bars.bar_level, "peak below bar")
    `ASSERT_NEVER(a_ready_while_busy, sample.ready && in_flight, "word taken with columns in flight")
    `ASSERT_CLK(a_clear_stays_idle, accept && sample.action |=> state_reg == S_IDLE, "clear left idle")

endmodule

`default_nettype wire

### verif/bar_animation_checker.sv
`timescale 1ns / 1ps
// Watches the sample, column and register ports of the level bar animator and predicts
// every column word from its own copy of bars, peaks and settings. Depends on lbaph_pkg.
module bar_animation_checker import lbaph_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    lbaph_sample_if                    sample,
    lbaph_bar_if                       bars,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         pending,
    output int                         failures,
    output int                         words_checked
);

    typedef struct packed {
        logic [COL_FIELD_W-1:0] column;
        logic [LVL_W-1:0]       bar_level;
        logic [LVL_W-1:0]       peak_level;
        logic                   last;
    } column_word_t;

    column_word_t expected_columns[$];

    logic [LVL_W-1:0]    bar_h  [COLUMNS];
    logic [LVL_W-1:0]    peak_h [COLUMNS];
    logic [7:0]          phase;
    logic [PERIOD_W-1:0] fall_count;

    logic [BYTE_W-1:0]   rssi_floor;
    logic [BYTE_W-1:0]   pause_gate;
    logic [PERIOD_W-1:0] fall_period;
    logic [THR_W-1:0]    thr [NTHR];

    int fail_count;
    int checked;

    function automatic void clear_bars();
        for (int c = 0; c < COLUMNS; c++)
        begin
            bar_h[c]  = '0;
            peak_h[c] = '0;
        end
        phase      = '0;
        fall_count = '0;
    endfunction

    function automatic int activity(logic [7:0] r, logic [7:0] s, logic rl);
        int d;
        if (rl || r < rssi_floor)
            return 0;
        d = int'(r) + 8 * int'(s);
        return (d > 255) ? 255 : d;
    endfunction

    // advance the fall counter; high when the peaks drop on this sample
    function automatic logic peak_drop_due();
        fall_count = fall_count + 1'b1;
        if (fall_count >= fall_period)
        begin
            fall_count = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int column_target(int unsigned act, int unsigned col);
        int unsigned ph;
        int unsigned h;
        int unsigned mix;
        int          tgt;
        int          wob;
        ph  = 32'(phase);
        h   = ((ph * 32'(HASH_PH_MUL)) ^ (col * 32'(HASH_COL_MUL)) ^
               (((ph + col) & 32'hFFFF) * 32'(HASH_SUM_MUL))) & 32'hFFFF;
        mix = (h ^ (h >> 8)) & 32'hFF;
        tgt = int'((act * (32'(SCALE_BASE) + mix % 32'(SCALE_MOD))) / 32'(ACT_MAX));
        if ((mix & 32'h7) == 0)
            tgt = tgt + int'(act >> 1);
        else if ((mix & 32'h7) == 1)
            tgt = tgt >>> 2;
        else if ((mix & 32'hF) == 2)
            tgt = tgt >>> 1;
        wob = int'((mix >> 3) & 32'h7) - 3;
        tgt = tgt + wob * int'(act >> 6);
        if (tgt < 0)
            tgt = 0;
        if (tgt > TARGET_MAX)
            tgt = TARGET_MAX;
        return tgt;
    endfunction

    // index of the last threshold reached, capped at LEVELS
    function automatic logic [LVL_W-1:0] level_of(int t);
        int lvl;
        lvl = 0;
        for (int i = 0; i < NTHR && i < LEVELS; i++)
            if (t >= int'(thr[i]))
                lvl = i + 1;
        if (lvl > LEVELS)
            lvl = LEVELS;
        return LVL_W'(lvl);
    endfunction

    function automatic void take_sample(logic [7:0] r, logic [7:0] s, logic rl);
        int               act;
        logic [LVL_W-1:0] want;
        column_word_t     w;
        act = activity(r, s, rl);
        if (act < int'(pause_gate))
        begin
            // collapse the bars, peaks keep what the bars had
            for (int c = 0; c < COLUMNS; c++)
            begin
                if (bar_h[c] > peak_h[c])
                    peak_h[c] = bar_h[c];
                bar_h[c] = '0;
            end
            if (peak_drop_due())
                for (int c = 0; c < COLUMNS; c++)
                    if (peak_h[c] != 0)
                        peak_h[c] = peak_h[c] - 1'b1;
        end
        else
        begin
            phase = phase + 8'd1;
            for (int c = 0; c < COLUMNS; c++)
            begin
                want = level_of(column_target(act, c));
                if (want > bar_h[c])
                    bar_h[c] = bar_h[c] + 1'b1;
                else if (want < bar_h[c])
                    bar_h[c] = bar_h[c] - 1'b1;
                if (bar_h[c] > peak_h[c])
                    peak_h[c] = bar_h[c];
            end
            if (peak_drop_due())
                for (int c = 0; c < COLUMNS; c++)
                    if (peak_h[c] > bar_h[c])
                        peak_h[c] = peak_h[c] - 1'b1;
        end
        for (int c = 0; c < COLUMNS; c++)
        begin
            w.column     = COL_FIELD_W'(c);
            w.bar_level  = bar_h[c];
            w.peak_level = peak_h[c];
            w.last       = (c == COLUMNS - 1);
            expected_columns.push_back(w);
        end
    endfunction

    function automatic void write_register();
        case (lbaph_cfg_idx_t'(cfg_index))
            CFG_RSSI_FLOOR: rssi_floor  = cfg_data[BYTE_W-1:0];
            CFG_PAUSE_GATE: pause_gate  = cfg_data[BYTE_W-1:0];
            CFG_FALL_PER:   fall_period = cfg_data[PERIOD_W-1:0];
            CFG_THR_ONE:    thr[0]      = cfg_data[THR_W-1:0];
            CFG_THR_TWO:    thr[1]      = cfg_data[THR_W-1:0];
            CFG_THR_THREE:  thr[2]      = cfg_data[THR_W-1:0];
            CFG_THR_FOUR:   thr[3]      = cfg_data[THR_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void check_column();
        column_word_t want;
        if (expected_columns.size() == 0)
        begin
            $error("column word %0d arrived with nothing expected", bars.column);
            fail_count++;
            return;
        end
        want = expected_columns.pop_front();
        checked++;
        if (bars.column !== want.column)
        begin
            $error("column: expected %0d, actual %0d", want.column, bars.column);
            fail_count++;
        end
        if (bars.bar_level !== want.bar_level)
        begin
            $error("bar_level: expected %0d, actual %0d (column %0d)",
                   want.bar_level, bars.bar_level, want.column);
            fail_count++;
        end
        if (bars.peak_level !== want.peak_level)
        begin
            $error("peak_level: expected %0d, actual %0d (column %0d)",
                   want.peak_level, bars.peak_level, want.column);
            fail_count++;
        end
        if (bars.last !== want.last)
        begin
            $error("last: expected %0d, actual %0d (column %0d)",
                   want.last, bars.last, want.column);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_bars();
            rssi_floor  = RSSI_FLOOR_RST;
            pause_gate  = PAUSE_GATE_RST;
            fall_period = FALL_PER_RST;
            for (int i = 0; i < NTHR; i++)
                thr[i] = THR_RST[i];
            expected_columns.delete();
            fail_count = 0;
            checked    = 0;
            pending       <= 0;
            failures      <= 0;
            words_checked <= 0;
        end
        else
        begin
            if (bars.valid && bars.ready)
                check_column();
            if (cfg_we)
                write_register();
            if (sample.valid && sample.ready)
            begin
                if (sample.action)
                    clear_bars();
                else
                    take_sample(sample.rssi, sample.snr, sample.railed);
            end
            pending       <= expected_columns.size();
            failures      <= fail_count;
            words_checked <= checked;
        end
    end

endmodule

### verif/level_bar_animator_peak_hold_test.sv
`timescale 1ns / 1ps
// Top of the level bar animator testbench: clock, reset, sample and register stimulus
// and the verdict. Depends on lbaph_pkg, lbaph_if and bar_animation_checker.
module level_bar_animator_peak_hold_test;
    import lbaph_pkg::*;

    localparam logic ACT_SAMPLE   = 1'b0;
    localparam logic ACT_CLEAR    = 1'b1;
    localparam int   DRAIN_CYCLES = 2 * COLUMNS + 16;
    localparam int   HOLD_CYCLES  = 400;
    localparam int   PHASE_WORDS  = 25;
    localparam int   PHASES       = 8;
    localparam int   LIMIT_NS     = 4_000_000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  hold_req;

    int idle_pct  = 0;
    int stall_pct = 0;
    int samples_sent  = 0;
    int clears_sent   = 0;
    int settings_used = 0;
    int pending;
    int failures;
    int words_checked;

    lbaph_sample_if sample_ch();
    lbaph_bar_if    bar_ch();

    level_bar_animator_peak_hold uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .bars      (bar_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bar_animation_checker animation_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample        (sample_ch),
        .bars          (bar_ch),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pending       (pending),
        .failures      (failures),
        .words_checked (words_checked)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial
    begin
        #LIMIT_NS;
        $display("Timeout with %0d column words still expected", pending);
        $display("Some tests failed");
        $finish;
    end

    // column sink: random stalls, plus one long hold-off on request
    initial
    begin : column_sink
        int hold_left;
        hold_left = 0;
        bar_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
                hold_left = HOLD_CYCLES;
            if (hold_left > 0)
            begin
                hold_left--;
                bar_ch.ready <= 1'b0;
            end
            else
                bar_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // valid stays high across back-to-back words; drop it only while idling
    task automatic send_word(input logic act, input logic [7:0] r, input logic [7:0] s,
                             input logic rl);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.action <= act;
        sample_ch.rssi   <= r;
        sample_ch.snr    <= s;
        sample_ch.railed <= rl;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        if (act == ACT_CLEAR)
            clears_sent++;
        else
            samples_sent++;
    endtask

    // mostly active and weak stretches so the bars climb and the peaks fall
    task automatic send_random_word();
        int         kind;
        logic [7:0] r;
        logic [7:0] s;
        logic       rl;
        kind = $urandom_range(0, 99);
        r    = 8'($urandom_range(0, 255));
        s    = 8'($urandom_range(0, 255));
        rl   = ($urandom_range(0, 7) == 0);
        if (kind < 6)
            send_word(ACT_CLEAR, r, s, rl);
        else if (kind < 30)
            send_word(ACT_SAMPLE, 8'($urandom_range(0, 30)), 8'($urandom_range(0, 3)),
                      ($urandom_range(0, 2) == 0));
        else if (kind < 70)
            send_word(ACT_SAMPLE, r, 8'($urandom_range(0, 31)), 1'b0);
        else
            send_word(ACT_SAMPLE, r, s, rl);
    endtask

    task automatic put_reg(input lbaph_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic load_settings(input logic [7:0] floor_v, input logic [7:0] gate_v,
                                 input logic [2:0] period_v,
                                 input logic [8:0] t1, input logic [8:0] t2,
                                 input logic [8:0] t3, input logic [8:0] t4);
        put_reg(CFG_RSSI_FLOOR, CFG_DATA_W'(floor_v));
        put_reg(CFG_PAUSE_GATE, CFG_DATA_W'(gate_v));
        put_reg(CFG_FALL_PER, CFG_DATA_W'(period_v));
        put_reg(CFG_THR_ONE, t1);
        put_reg(CFG_THR_TWO, t2);
        put_reg(CFG_THR_THREE, t3);
        put_reg(CFG_THR_FOUR, t4);
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // wait until every column word is in, then let the block go quiet
    task automatic settle();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int         mode;
        logic [8:0] t1;
        logic [8:0] t2;
        logic [8:0] t3;
        logic [8:0] t4;

        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= CFG_RSSI_FLOOR;
        cfg_data         <= '0;
        hold_req         <= 1'b0;
        sample_ch.valid  <= 1'b0;
        sample_ch.action <= ACT_SAMPLE;
        sample_ch.rssi   <= '0;
        sample_ch.snr    <= '0;
        sample_ch.railed <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part on the reset settings
        send_word(ACT_SAMPLE, 8'd0, 8'd0, 1'b0);
        send_word(ACT_SAMPLE, 8'd255, 8'd255, 1'b0);
        repeat (6) send_word(ACT_SAMPLE, 8'd200, 8'd20, 1'b0);
        // railed: bars collapse, peaks hold
        send_word(ACT_SAMPLE, 8'd255, 8'd255, 1'b1);
        // one below the floor; long enough for the peaks to fall
        repeat (6) send_word(ACT_SAMPLE, 8'd9, 8'd255, 1'b0);
        send_word(ACT_SAMPLE, 8'd10, 8'd0, 1'b0);
        send_word(ACT_SAMPLE, 8'd18, 8'd0, 1'b0);
        send_word(ACT_SAMPLE, 8'd17, 8'd0, 1'b0);
        send_word(ACT_SAMPLE, 8'd100, 8'd5, 1'b0);
        send_word(ACT_CLEAR, 8'd255, 8'd255, 1'b1);
        send_word(ACT_SAMPLE, 8'd50, 8'd25, 1'b0);
        send_word(ACT_CLEAR, 8'd0, 8'd0, 1'b0);
        send_word(ACT_CLEAR, 8'd0, 8'd0, 1'b0);
        send_word(ACT_SAMPLE, 8'd255, 8'd0, 1'b0);
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: load_settings(8'd0, 8'd0, 3'd0, 9'd0, 9'd0, 9'd0, 9'd0);
                1: load_settings(8'd255, 8'd255, 3'd7, 9'd511, 9'd511, 9'd511, 9'd511);
                2: load_settings(8'd10, 8'd18, 3'd1, 9'd300, 9'd10, 9'd200, 9'd50);
                3: load_settings(RSSI_FLOOR_RST, PAUSE_GATE_RST, FALL_PER_RST,
                                 THR_RST[0], THR_RST[1], THR_RST[2], THR_RST[3]);
                default:
                begin
                    t1 = 9'($urandom_range(0, 150));
                    t2 = t1 + 9'($urandom_range(0, 120));
                    t3 = t2 + 9'($urandom_range(0, 120));
                    t4 = t3 + 9'($urandom_range(0, 120));
                    load_settings(8'($urandom_range(0, 64)), 8'($urandom_range(0, 160)),
                                  3'($urandom_range(0, 7)), t1, t2, t3, t4);
                end
            endcase
            mode = p % 4;
            idle_pct = (mode == 1) ? 80 : (mode == 3) ? 19 : 0;
            stall_pct <= (mode == 2) ? 80 : (mode == 3) ? 19 : 0;
            if (p == 0)
            begin
                // hold the column sink off while samples keep coming
                hold_req <= 1'b1;
                @(posedge clk);
                hold_req <= 1'b0;
            end
            repeat (PHASE_WORDS) send_random_word();
            settle();
        end

        $display("Run covered %0d sample and %0d clear words under %0d register settings,",
                 samples_sent, clears_sent, settings_used + 1);
        $display("with %0d column words checked across all idle and stall patterns.",
                 words_checked);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
